// File: hdl/nsf_pkg.sv
// shared constants, codes and helper functions of the nmea sentence framer
package nsf_pkg;

  // longest line kept, the newline not counted, is LINE_CAPACITY - 2 bytes
  localparam int LINE_CAPACITY = 256;
  localparam int LEN_W = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h0A;  // newline
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','

  localparam int NUM_HEADERS = 6;
  localparam int HEADER_LEN  = 6;

  // header i owns bit i of the prefix match vector
  localparam logic [0:NUM_HEADERS-1][8*HEADER_LEN-1:0] HEADERS = '{
    "$GPGGA", "$GNGGA", "$GPRMC", "$GNRMC", "$GPGSA", "$GNGSA"
  };

  localparam logic [7:0] MIN_FIELDS_ANY = 8'd2;
  localparam logic [7:0] MIN_FIELDS_GGA = 8'd14;
  localparam logic [7:0] MIN_FIELDS_RMC = 8'd12;
  localparam logic [7:0] MIN_FIELDS_GSA = 8'd18;
  localparam logic [7:0] COMMA_MAX      = 8'd255;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_UNKNOWN    = 3'd1,
    ST_BAD_START  = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_SUM_ERROR  = 3'd4,
    ST_FEW_FIELDS = 3'd5
  } line_status_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_RMC   = 2'd2,
    KIND_GSA   = 2'd3
  } sentence_kind_e;

  // byte number pos of header idx
  function automatic logic [7:0] header_byte(input int idx, input logic [2:0] pos);
    logic [8*HEADER_LEN-1:0] hdr;
    hdr = HEADERS[idx];
    return hdr[8*(HEADER_LEN-1-int'(pos)) +: 8];
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

endpackage

// File: hdl/nsf_rx_if.sv
// valid/ready channel that carries one received serial byte
interface nsf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/nsf_line_if.sv
// valid/ready channel that carries one line verdict
interface nsf_line_if;
  logic        valid;
  logic        ready;
  logic [2:0]  line_status;
  logic [1:0]  sentence_kind;
  logic [7:0]  fields_in_line;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;
  logic [31:0] good_lines;
  logic [31:0] sum_failures;
  logic [31:0] start_failures;

  modport source (
    output valid, output line_status, output sentence_kind, output fields_in_line,
    output computed_sum, output received_sum, output good_lines, output sum_failures,
    output start_failures, input ready
  );
  modport sink (
    input valid, input line_status, input sentence_kind, input fields_in_line,
    input computed_sum, input received_sum, input good_lines, input sum_failures,
    input start_failures, output ready
  );
endinterface

// File: hdl/nmea_sentence_framer_top.sv
// top level of the nmea sentence framer: line framing, checksum and verdict logic
//
// Accepts one received serial byte per cycle on rx_i and gives one verdict on line_o
// for each newline byte; other bytes give no transaction. A byte is held in the
// input register, where the per-line summaries (running xor, hex checksum digits,
// comma count, header prefix match) are updated, and a verdict then sits in the
// output register until taken. Sustained rate is one byte per cycle; the only thing
// that slows it is a stalled verdict, which holds back a following newline byte
// while ordinary bytes keep flowing. A newline passes through both registers. A line
// that reaches LINE_CAPACITY - 1 bytes without a newline is dropped silently and the
// next byte starts a new line. Counters wrap at 32 bits.
module nmea_sentence_framer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  nsf_rx_if.sink       rx_i,
  nsf_line_if.source   line_o
);

  localparam int LW = nsf_pkg::LEN_W;
  localparam logic [LW-1:0] LEN_LIMIT = LW'(nsf_pkg::LINE_CAPACITY - 1);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // per-line summaries
  logic [LW-1:0] len_q, len_d;
  logic          first_q, first_d;
  logic [7:0]    xor_q, xor_d;
  logic          star_q, star_d;
  logic [1:0]    hexn_q, hexn_d;
  logic [7:0]    hexv_q, hexv_d;
  logic          hexstop_q, hexstop_d;
  logic [nsf_pkg::NUM_HEADERS-1:0] prefix_q, prefix_d;
  logic [7:0]    comma_q, comma_d;

  // running counters
  logic [31:0] good_q, good_d;
  logic [31:0] sumerr_q, sumerr_d;
  logic [31:0] starterr_q, starterr_d;

  // output register
  logic                    out_valid_q;
  nsf_pkg::line_status_e   out_status_q, status_d;
  nsf_pkg::sentence_kind_e out_kind_q, kind_d;
  logic [7:0]              out_fields_q, fields_d;
  logic [7:0]              out_xor_q;
  logic [7:0]              out_hex_q;

  logic is_end;
  logic in_fire;   // input register moves on this cycle
  logic out_load;  // verdict enters the output register
  logic out_free;

  assign is_end   = (in_byte_q == nsf_pkg::CH_END);
  assign out_free = !out_valid_q || line_o.ready;
  assign in_fire  = in_valid_q && (!is_end || out_free);
  assign out_load = in_fire && is_end;

  // input can advance whenever the held byte does
  assign rx_i.ready = !in_valid_q || in_fire;

  // per-byte update of the line summaries
  always_comb begin
    logic [4:0]    hd;
    logic [LW-1:0] len_inc;
    first_d   = first_q;
    xor_d     = xor_q;
    star_d    = star_q;
    hexn_d    = hexn_q;
    hexv_d    = hexv_q;
    hexstop_d = hexstop_q;
    prefix_d  = prefix_q;
    comma_d   = comma_q;
    hd        = nsf_pkg::hex_digit(in_byte_q);
    len_inc   = len_q + LW'(1);
    len_d     = len_inc;

    if (len_q == '0) begin
      first_d = (in_byte_q == nsf_pkg::CH_START);
    end
    if (len_q < LW'(nsf_pkg::HEADER_LEN)) begin
      for (int i = 0; i < nsf_pkg::NUM_HEADERS; i++) begin
        if (nsf_pkg::header_byte(i, len_q[2:0]) != in_byte_q) begin
          prefix_d[i] = 1'b0;
        end
      end
    end
    if (in_byte_q == nsf_pkg::CH_COMMA && comma_q != nsf_pkg::COMMA_MAX) begin
      comma_d = comma_q + 8'd1;
    end
    if (star_q) begin
      // up to two hex digits right after the star
      if (!hexstop_q && hexn_q != 2'd2) begin
        if (!hd[4]) begin
          hexstop_d = 1'b1;
        end else begin
          hexv_d = {hexv_q[3:0], hd[3:0]};
          hexn_d = hexn_q + 2'd1;
        end
      end
    end else if (in_byte_q == nsf_pkg::CH_STAR) begin
      star_d = 1'b1;
    end else if (len_q != '0) begin
      xor_d = xor_q ^ in_byte_q;
    end
  end

  // verdict for a newline, from the summaries held so far
  always_comb begin
    good_d     = good_q;
    sumerr_d   = sumerr_q;
    starterr_d = starterr_q;
    kind_d     = nsf_pkg::KIND_OTHER;
    if (len_q >= LW'(nsf_pkg::HEADER_LEN)) begin
      if (prefix_q[1:0] != 2'b00) begin
        kind_d = nsf_pkg::KIND_GGA;
      end else if (prefix_q[3:2] != 2'b00) begin
        kind_d = nsf_pkg::KIND_RMC;
      end else if (prefix_q[5:4] != 2'b00) begin
        kind_d = nsf_pkg::KIND_GSA;
      end
    end
    fields_d = (comma_q != nsf_pkg::COMMA_MAX) ? comma_q + 8'd1 : nsf_pkg::COMMA_MAX;

    if (len_q == '0 || !first_q) begin
      status_d   = nsf_pkg::ST_BAD_START;
      starterr_d = starterr_q + 32'd1;
    end else if (len_q < LW'(2)) begin
      // "$" alone before the newline
      status_d = nsf_pkg::ST_TOO_SHORT;
    end else if (!star_q || xor_q != hexv_q) begin
      status_d = nsf_pkg::ST_SUM_ERROR;
      sumerr_d = sumerr_q + 32'd1;
    end else begin
      good_d = good_q + 32'd1;
      if (fields_d < nsf_pkg::MIN_FIELDS_ANY) begin
        status_d = nsf_pkg::ST_FEW_FIELDS;
      end else begin
        case (kind_d)
          nsf_pkg::KIND_GGA: status_d = (fields_d < nsf_pkg::MIN_FIELDS_GGA) ?
                                        nsf_pkg::ST_FEW_FIELDS : nsf_pkg::ST_ACCEPTED;
          nsf_pkg::KIND_RMC: status_d = (fields_d < nsf_pkg::MIN_FIELDS_RMC) ?
                                        nsf_pkg::ST_FEW_FIELDS : nsf_pkg::ST_ACCEPTED;
          nsf_pkg::KIND_GSA: status_d = (fields_d < nsf_pkg::MIN_FIELDS_GSA) ?
                                        nsf_pkg::ST_FEW_FIELDS : nsf_pkg::ST_ACCEPTED;
          default:           status_d = nsf_pkg::ST_UNKNOWN;
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // line state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      first_q    <= 1'b0;
      xor_q      <= 8'd0;
      star_q     <= 1'b0;
      hexn_q     <= 2'd0;
      hexv_q     <= 8'd0;
      hexstop_q  <= 1'b0;
      prefix_q   <= '1;
      comma_q    <= 8'd0;
      good_q     <= 32'd0;
      sumerr_q   <= 32'd0;
      starterr_q <= 32'd0;
    end else if (in_fire) begin
      if (is_end || len_d >= LEN_LIMIT) begin
        // newline ends the line, overflow drops it
        len_q     <= '0;
        first_q   <= 1'b0;
        xor_q     <= 8'd0;
        star_q    <= 1'b0;
        hexn_q    <= 2'd0;
        hexv_q    <= 8'd0;
        hexstop_q <= 1'b0;
        prefix_q  <= '1;
        comma_q   <= 8'd0;
      end else begin
        len_q     <= len_d;
        first_q   <= first_d;
        xor_q     <= xor_d;
        star_q    <= star_d;
        hexn_q    <= hexn_d;
        hexv_q    <= hexv_d;
        hexstop_q <= hexstop_d;
        prefix_q  <= prefix_d;
        comma_q   <= comma_d;
      end
      if (is_end) begin
        good_q     <= good_d;
        sumerr_q   <= sumerr_d;
        starterr_q <= starterr_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (line_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_d;
      out_kind_q   <= kind_d;
      out_fields_q <= fields_d;
      out_xor_q    <= xor_q;
      out_hex_q    <= hexv_q;
    end
  end

  assign line_o.valid          = out_valid_q;
  assign line_o.line_status    = out_status_q;
  assign line_o.sentence_kind  = out_kind_q;
  assign line_o.fields_in_line = out_fields_q;
  assign line_o.computed_sum   = out_xor_q;
  assign line_o.received_sum   = out_hex_q;
  // counters already hold the value after the verdict shown
  assign line_o.good_lines     = good_q;
  assign line_o.sum_failures   = sumerr_q;
  assign line_o.start_failures = starterr_q;

  // line length never reaches the overflow limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q < LEN_LIMIT)
    else $error("line length reached overflow limit");

  // a verdict is loaded only for a newline byte
  a_load_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (in_byte_q == nsf_pkg::CH_END) && out_free)
    else $error("verdict loaded without newline or over a pending verdict");

  // counters move only with a verdict
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(good_q) && $stable(sumerr_q) && $stable(starterr_q))
    else $error("counter changed without a verdict");

  // an accepted line always has a known kind
  a_accept_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == nsf_pkg::ST_ACCEPTED) |->
      out_kind_q != nsf_pkg::KIND_OTHER)
    else $error("accepted line with unknown kind");

endmodule
